### rtl/ez2r_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the ZYX Euler-to-rotation block.
// No dependencies; used by every module in rtl/.
package ez2r_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int FIELD_W      = 16;

    // CORDIC datapath: fraction bits of x/y, guard bits below one angle unit, iterations
    localparam int CORDIC_D     = 48;
    localparam int CORDIC_G     = 32;
    localparam int CORDIC_ITERS = 48;

    localparam real PI_R        = 3.14159265358979323846;
    localparam real CORDIC_K    = 0.6072529350088812561694;
    localparam longint CORDIC_X0 = longint'(CORDIC_K * (2.0 ** CORDIC_D));

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] roll_angle;
        logic signed [FIELD_W-1:0] pitch_angle;
        logic signed [FIELD_W-1:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m10;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m20;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
    } t_matrix;

    // atan(2^-i) in radians
    function automatic real atan_pow2(int i);
        real x;
        x = 2.0 ** (-i);
        unique case (i)
            0: return 0.78539816339744830962;
            1: return 0.46364760900080611621;
            2: return 0.24497866312686415417;
            3: return 0.12435499454676143503;
            4: return 0.06241880999595734847;
            default: return x - (x ** 3) / 3.0 + (x ** 5) / 5.0 - (x ** 7) / 7.0;
        endcase
    endfunction

    // atan(2^-i) in angle units with guard bits: a quarter turn is 2^(ab-2+G)
    function automatic longint atan_units(int i, int ab);
        return longint'(atan_pow2(i) * (2.0 ** (ab - 2 + CORDIC_G)) * 2.0 / PI_R);
    endfunction

endpackage

### rtl/ez2r_front.sv
`timescale 1ns / 1ps
// Front end: accepts angle triples, splits each angle into quadrant and remainder,
// and holds them in a two-entry queue for the back end. Depends on ez2r_pkg.
module ez2r_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ez2r_pkg::t_angles  i_angles,
    output logic               o_busy,
    output logic               o_valid,
    output logic [1:0]         o_quad [3],
    output logic [ANGLE_BITS-3:0] o_rem [3]
);
    import ez2r_pkg::*;

    localparam int WW = 3 * ANGLE_BITS;

    logic [WW-1:0] r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    logic [WW-1:0] word_in;
    logic [WW-1:0] word_out;

    // keep only the low ANGLE_BITS of each angle (wraps modulo a full turn)
    assign word_in = {ANGLE_BITS'(i_angles.roll_angle),
                      ANGLE_BITS'(i_angles.pitch_angle),
                      ANGLE_BITS'(i_angles.yaw_angle)};

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign pop     = (r_cnt != 2'd0);
    assign o_valid = pop;
    assign word_out = r_mem[r_rd];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_quad[k] = word_out[WW-1-k*ANGLE_BITS -: 2];
            o_rem[k]  = word_out[WW-3-k*ANGLE_BITS -: ANGLE_BITS-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= word_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

### rtl/ez2r_cordic.sv
`timescale 1ns / 1ps
// One pipelined CORDIC lane: sine and cosine of a binary angle, rounded to Q1.FRAC_BITS.
// One iteration per stage, quadrant fixed up at the end. Depends on ez2r_pkg.
module ez2r_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                        i_clk,
    input  logic [1:0]                  i_quad,
    input  logic [ANGLE_BITS-3:0]       i_rem,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos
);
    import ez2r_pkg::*;

    localparam int N  = CORDIC_ITERS;
    localparam int XW = CORDIC_D + 2;
    localparam int ZW = ANGLE_BITS + CORDIC_G;
    localparam int SH = CORDIC_D - FRAC_BITS;
    localparam int QW = FRAC_BITS + 2;

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    logic [1:0]           r_q [N+1];

    logic signed [XW-1:0] x_rnd;
    logic signed [XW-1:0] y_rnd;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    logic signed [QW-1:0] sq;
    logic signed [QW-1:0] cq;
    logic signed [QW-1:0] n_sin;
    logic signed [QW-1:0] n_cos;

    always_ff @(posedge i_clk) begin
        r_x[0] <= XW'(CORDIC_X0);
        r_y[0] <= '0;
        r_z[0] <= signed'({2'b00, i_rem, {CORDIC_G{1'b0}}});
        r_q[0] <= i_quad;
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_units(k, ANGLE_BITS));
        always_ff @(posedge i_clk) begin
            if (r_z[k][ZW-1]) begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN;
            end else begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN;
            end
            r_q[k+1] <= r_q[k];
        end
    end

    // round to nearest Q1.FRAC_BITS
    assign x_rnd = r_x[N] + (XW'(1) <<< (SH - 1));
    assign y_rnd = r_y[N] + (XW'(1) <<< (SH - 1));
    assign x_sh  = x_rnd >>> SH;
    assign y_sh  = y_rnd >>> SH;
    assign sq    = y_sh[QW-1:0];
    assign cq    = x_sh[QW-1:0];

    always_comb begin
        unique case (r_q[N])
            QUAD_0: begin n_sin = sq;  n_cos = cq;  end
            QUAD_1: begin n_sin = cq;  n_cos = -sq; end
            QUAD_2: begin n_sin = -sq; n_cos = -cq; end
            QUAD_3: begin n_sin = -cq; n_cos = sq;  end
            default: begin n_sin = sq; n_cos = cq;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_sin <= n_sin;
        o_cos <= n_cos;
    end

endmodule

### rtl/ez2r_back.sv
`timescale 1ns / 1ps
// Back end: three CORDIC lanes, then products, sums, rounding and saturation of the
// nine matrix entries in three registered steps. Depends on ez2r_pkg, ez2r_cordic.
module ez2r_back #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [1:0]            i_quad [3],
    input  logic [ANGLE_BITS-3:0] i_rem [3],
    output logic                  o_valid,
    output ez2r_pkg::t_matrix     o_result
);
    import ez2r_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 2;
    localparam int PW  = 2 * QW;
    localparam int V   = 3 * QW;
    localparam int LAT = CORDIC_ITERS + 5;

    logic signed [QW-1:0] s [3];
    logic signed [QW-1:0] c [3];

    logic [LAT-1:0] r_vld;

    logic signed [PW-1:0] r_spcy, r_spsy, r_cpcy, r_crsy, r_srsy;
    logic signed [PW-1:0] r_cpsy, r_crcy, r_srcy, r_srcp, r_crcp;
    logic signed [QW-1:0] r_sr, r_cr, r_sp;

    logic signed [V-1:0] r_pa [9];
    logic signed [V-1:0] r_pb [9];

    t_matrix r_result;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        ez2r_cordic #(
            .ANGLE_BITS (ANGLE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cordic (
            .i_clk  (i_clk),
            .i_quad (i_quad[k]),
            .i_rem  (i_rem[k]),
            .o_sin  (s[k]),
            .o_cos  (c[k])
        );
    end

    // round half away from zero at scale 2^(2F), saturate to +/- 2^F
    function automatic logic [FIELD_W-1:0] entry(logic signed [V-1:0] a,
                                                 logic signed [V-1:0] b);
        logic signed [V:0]    sum;
        logic [V:0]           mag;
        logic [V:0]           q;
        logic signed [QW-1:0] e;
        sum = (V+1)'(a) + (V+1)'(b);
        mag = sum[V] ? (V+1)'(-sum) : (V+1)'(sum);
        q   = (mag + ((V+1)'(1) << (2*F - 1))) >> (2*F);
        if (q > ((V+1)'(1) << F)) begin
            q = (V+1)'(1) << F;
        end
        e = sum[V] ? -signed'(q[QW-1:0]) : signed'(q[QW-1:0]);
        return FIELD_W'(e);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_spcy <= s[1] * c[2];
        r_spsy <= s[1] * s[2];
        r_cpcy <= c[1] * c[2];
        r_crsy <= c[0] * s[2];
        r_srsy <= s[0] * s[2];
        r_cpsy <= c[1] * s[2];
        r_crcy <= c[0] * c[2];
        r_srcy <= s[0] * c[2];
        r_srcp <= s[0] * c[1];
        r_crcp <= c[0] * c[1];
        r_sr   <= s[0];
        r_cr   <= c[0];
        r_sp   <= s[1];
    end

    always_ff @(posedge i_clk) begin
        r_pa[0] <= V'(r_cpcy) <<< F;
        r_pa[1] <= r_sr * r_spcy;
        r_pa[2] <= r_cr * r_spcy;
        r_pa[3] <= V'(r_cpsy) <<< F;
        r_pa[4] <= r_sr * r_spsy;
        r_pa[5] <= r_cr * r_spsy;
        r_pa[6] <= -(V'(r_sp) <<< (2*F));
        r_pa[7] <= V'(r_srcp) <<< F;
        r_pa[8] <= V'(r_crcp) <<< F;
        r_pb[0] <= '0;
        r_pb[1] <= -(V'(r_crsy) <<< F);
        r_pb[2] <= V'(r_srsy) <<< F;
        r_pb[3] <= '0;
        r_pb[4] <= V'(r_crcy) <<< F;
        r_pb[5] <= -(V'(r_srcy) <<< F);
        r_pb[6] <= '0;
        r_pb[7] <= '0;
        r_pb[8] <= '0;
    end

    always_ff @(posedge i_clk) begin
        r_result.m00 <= entry(r_pa[0], r_pb[0]);
        r_result.m01 <= entry(r_pa[1], r_pb[1]);
        r_result.m02 <= entry(r_pa[2], r_pb[2]);
        r_result.m10 <= entry(r_pa[3], r_pb[3]);
        r_result.m11 <= entry(r_pa[4], r_pb[4]);
        r_result.m12 <= entry(r_pa[5], r_pb[5]);
        r_result.m20 <= entry(r_pa[6], r_pb[6]);
        r_result.m21 <= entry(r_pa[7], r_pb[7]);
        r_result.m22 <= entry(r_pa[8], r_pb[8]);
    end

    assign o_valid  = r_vld[LAT-1];
    assign o_result = r_result;

endmodule

### rtl/euler_zyx_to_rotation.sv
`timescale 1ns / 1ps
// ZYX Euler angles (roll, pitch, yaw) to 3x3 rotation matrix in signed Q1.FRAC_BITS.
// Top level: front queue plus CORDIC/matrix back end. Depends on ez2r_pkg, ez2r_front,
// ez2r_back.
//
// Usage:
//   Drive i_angles and raise start; the item is taken at each rising edge where start
//   is high and busy is low. Items may be sent every cycle.
//   Each result appears on o_result for exactly one cycle with o_valid high; the
//   receiver cannot stall, so capture it then.
// An accepted item goes from the front queue, written at the accepting edge and feeding
//   the lanes at once, through the sine/cosine lanes (input register, iteration stages,
//   output register) to the back end's registered products, sums and rounding.
// Throughput: one item per cycle, set by the fully pipelined CORDIC lanes; the back
//   end never stalls, so the two-entry queue drains every cycle and busy stays low.
// Reset: synchronous, active low; clears the queue and the valid chain, so items in
//   flight are dropped and no result is shown until new items have passed through.
// Results come out in the order items went in, one result per item.
module euler_zyx_to_rotation #(
    parameter int ANGLE_BITS = ez2r_pkg::ANGLE_BITS,
    parameter int FRAC_BITS  = ez2r_pkg::FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ez2r_pkg::t_angles i_angles,
    output logic              busy,
    output logic              o_valid,
    output ez2r_pkg::t_matrix o_result
);
    import ez2r_pkg::*;

    localparam int LAT = CORDIC_ITERS + 6;

    // front to back: one queued item, split into quadrant and remainder per angle
    logic                  q_valid;
    logic [1:0]            q_quad [3];
    logic [ANGLE_BITS-3:0] q_rem [3];

    // accept and classify; hold in a short queue
    ez2r_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_angles (i_angles),
        .o_busy   (busy),
        .o_valid  (q_valid),
        .o_quad   (q_quad),
        .o_rem    (q_rem)
    );

    // advance one item per cycle through sine/cosine and the matrix products
    ez2r_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_quad   (q_quad),
        .i_rem    (q_rem),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    localparam logic signed [FIELD_W-1:0] ONE16 = FIELD_W'(1 << FRAC_BITS);

    // back end never stalls, so the queue never fills
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("front queue filled up");

    // every accepted item yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after pipeline latency");

    // diagonal entries m00 and m22 stay within the saturation bound
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.m22 <= ONE16) && (o_result.m22 >= -ONE16)
                 && (o_result.m00 <= ONE16) && (o_result.m00 >= -ONE16))
        else $error("matrix entry out of range");
`endif

endmodule
